@@ rtl/core/orq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the ordered ready queue.
// Used by orq_cell and ordered_ready_queue; depends on nothing else.
package orq_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_W    = 16;
    localparam int PRIO_W  = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_ORDERED = 2'd0,
        FUNC_FRONT   = 2'd1,
        FUNC_REMOVE  = 2'd2,
        FUNC_QUERY   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_ORDERED = 2'd1,
        CMD_FRONT   = 2'd2,
        CMD_REMOVE  = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_cmd;

endpackage

@@ rtl/core/ordered_ready_queue.sv @@
`timescale 1ns / 1ps
// Top level of the ordered ready queue: a row of orq_cell slots, fill count, result register.
// Depends on orq_pkg and orq_cell.
//
//  Channel   Handshake            Word
//  request   i_valid / o_ready    i_func, i_thread_id, i_priority_req
//  result    o_valid / i_ready    o_status, o_found, o_count, o_head_valid, o_head_id
//
// One request word is taken per clock cycle while the result register is free or being taken,
// and its result word is captured in the result register at the accepting edge. The result
// comes from the compare-and-shift pass through the row of DEPTH cells: each cell compares in
// parallel and a one-bit chain picks the first matching slot.
// Reset (synchronous, active low) empties the queue; slot contents are not cleared.
// A stalled result holds o_ready low only while the result register is full and not taken.
module ordered_ready_queue
    import orq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_func,
    input  logic [ID_W-1:0]   i_thread_id,
    input  logic [PRIO_W-1:0] i_priority_req,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic              o_found,
    output logic [CNT_W-1:0]  o_count,
    output logic              o_head_valid,
    output logic [ID_W-1:0]   o_head_id
);

    logic               accept;
    logic               full;
    logic               found;
    t_cmd               cmd;
    t_status            status;
    logic [CNT_W-1:0]   n_fill;
    logic [CNT_W-1:0]   r_fill;
    logic               r_out_valid;
    t_status            r_status;
    logic               r_found;
    logic [CNT_W-1:0]   r_count;
    logic               r_head_valid;
    logic [ID_W-1:0]    r_head_id;

    t_entry             cur   [DEPTH];
    t_entry             nxt   [DEPTH];
    logic [DEPTH:0]     ins_chain;
    logic [DEPTH:0]     id_chain;

    // The result register parts the two sides: a new word enters whenever the
    // held result is absent or is being taken in this cycle.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign full    = (r_fill == CNT_W'(DEPTH));
    assign found   = id_chain[DEPTH];

    // Decode the request into a cell command. Refused inserts and queries leave the cells alone.
    always_comb begin
        cmd    = '{kind: CMD_NONE, id: i_thread_id, prio: i_priority_req};
        status = STAT_DONE;
        n_fill = r_fill;
        unique case (t_func'(i_func))
            FUNC_ORDERED, FUNC_FRONT: begin
                if (full) begin
                    status = STAT_FULL;
                end else begin
                    cmd.kind = (t_func'(i_func) == FUNC_ORDERED) ? CMD_ORDERED : CMD_FRONT;
                    n_fill   = r_fill + CNT_W'(1);
                end
            end
            FUNC_REMOVE: begin
                if (found) begin
                    cmd.kind = CMD_REMOVE;
                    n_fill   = r_fill - CNT_W'(1);
                end else begin
                    status = STAT_NOTFOUND;
                end
            end
            FUNC_QUERY: begin
                status = found ? STAT_DONE : STAT_NOTFOUND;
            end
            default: begin
            end
        endcase
        if (!accept) begin
            cmd.kind = CMD_NONE;
        end
    end

    // Slot 0 is the head. Inserts shift toward the tail, removals toward the head.
    assign ins_chain[0] = 1'b0;
    assign id_chain[0]  = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry left_e;
            t_entry right_e;
            if (g == 0) begin : g_first
                assign left_e = '0;
            end else begin : g_mid
                assign left_e = cur[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_e = '0;
            end else begin : g_inner
                assign right_e = cur[g+1];
            end
            orq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (cmd),
                .i_left      (left_e),
                .i_right     (right_e),
                .i_ins_chain (ins_chain[g]),
                .i_id_chain  (id_chain[g]),
                .o_ins_chain (ins_chain[g+1]),
                .o_id_chain  (id_chain[g+1]),
                .o_entry     (cur[g]),
                .o_next      (nxt[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The count and head report the queue as it stands after the request; found reflects it before.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= status;
            r_found      <= found;
            r_count      <= n_fill;
            r_head_valid <= (n_fill != '0);
            r_head_id    <= (n_fill != '0) ? nxt[0].id : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_found      = r_found;
    assign o_count      = r_count;
    assign o_head_valid = r_head_valid;
    assign o_head_id    = r_head_id;

endmodule

@@ rtl/core/orq_cell.sv @@
`timescale 1ns / 1ps
// One slot of the ordered ready queue: holds an entry and shifts with its neighbors.
// Depends on orq_pkg.
module orq_cell
    import orq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cmd   i_cmd,
    input  t_entry i_left,
    input  t_entry i_right,
    input  logic   i_ins_chain,
    input  logic   i_id_chain,
    output logic   o_ins_chain,
    output logic   o_id_chain,
    output t_entry o_entry,
    output t_entry o_next
);

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    t_entry            n_entry;
    logic              match;
    logic              hit;
    logic              own;

    // A cell marks the insert point if empty or the new count is not below its own, or always on a front insert.
    assign match       = r_valid && (r_id == i_cmd.id);
    assign hit         = !r_valid || (i_cmd.prio >= r_prio);
    assign own         = (i_cmd.kind == CMD_FRONT) || ((i_cmd.kind == CMD_ORDERED) && hit);
    assign o_ins_chain = i_ins_chain || own;
    assign o_id_chain  = i_id_chain || match;
    assign o_entry     = '{valid: r_valid, id: r_id, prio: r_prio};
    assign o_next      = n_entry;

    always_comb begin
        n_entry = '{valid: r_valid, id: r_id, prio: r_prio};
        case (i_cmd.kind)
            CMD_ORDERED, CMD_FRONT: begin
                if (i_ins_chain) begin
                    n_entry = i_left;
                end else if (own) begin
                    n_entry = '{valid: 1'b1, id: i_cmd.id, prio: i_cmd.prio};
                end
            end
            CMD_REMOVE: begin
                if (o_id_chain) begin
                    n_entry = i_right;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_id   <= n_entry.id;
        r_prio <= n_entry.prio;
    end

endmodule

@@ tb/sv/tb_ordered_ready_queue.sv @@
`timescale 1ns / 1ps
// Self-checking bench for ordered_ready_queue: a directed opening, then phased random traffic.
// A shadow queue predicts every result word. Depends on orq_pkg and the ordered_ready_queue RTL.
module tb_ordered_ready_queue;
    import orq_pkg::*;

    localparam int RANDOM_WORDS = 1525;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int POOL_SIZE    = 12;

    // One request word as it goes onto the request channel.
    typedef struct packed {
        t_func             func;
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } t_request;

    // One result word as the queue should report it.
    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [CNT_W-1:0] count;
        logic             head_valid;
        logic [ID_W-1:0]  head_id;
    } t_outcome;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_func = FUNC_QUERY;
    logic [ID_W-1:0]   i_thread_id = '0;
    logic [PRIO_W-1:0] i_priority_req = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [1:0]        o_status;
    logic              o_found;
    logic [CNT_W-1:0]  o_count;
    logic              o_head_valid;
    logic [ID_W-1:0]   o_head_id;

    ordered_ready_queue u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_thread_id    (i_thread_id),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_count        (o_count),
        .o_head_valid   (o_head_valid),
        .o_head_id      (o_head_id)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Shadow copy of the slot row, kept in order from the head.
    logic [ID_W-1:0]   shadow_ids   [DEPTH];
    logic [PRIO_W-1:0] shadow_prios [DEPTH];
    int                shadow_fill = 0;

    t_request requests_pending [$];
    t_outcome outcomes_due     [$];
    t_request word_on_bus;
    int       burst_left = 0;
    int       gap_left = 0;
    int       words_taken = 0;
    int       hold_left = 0;
    int       next_hold_at = 150;
    int       rx_mode = 0;
    int       rx_left = 0;
    int       errors = 0;
    int       cycles = 0;

    // Applies one request to the shadow queue and returns the result word it should give.
    function automatic t_outcome queue_apply(input t_request req);
        t_outcome res;
        int       hit;
        int       pos;
        hit = -1;
        for (int i = 0; i < shadow_fill; i++)
            if (hit < 0 && shadow_ids[i] == req.id)
                hit = i;
        res.status = STAT_DONE;
        case (req.func)
            FUNC_ORDERED, FUNC_FRONT: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    // The ordered walk stops at the first stored count that is not greater
                    // than the new one, so the newest of equal counts ends up first.
                    pos = 0;
                    if (req.func == FUNC_ORDERED) begin
                        pos = shadow_fill;
                        for (int i = 0; i < shadow_fill; i++)
                            if (pos == shadow_fill && req.prio >= shadow_prios[i])
                                pos = i;
                    end
                    for (int i = shadow_fill; i > pos; i--) begin
                        shadow_ids[i]   = shadow_ids[i-1];
                        shadow_prios[i] = shadow_prios[i-1];
                    end
                    shadow_ids[pos]   = req.id;
                    shadow_prios[pos] = req.prio;
                    shadow_fill++;
                end
            end
            FUNC_REMOVE: begin
                if (hit < 0) begin
                    res.status = STAT_NOTFOUND;
                end else begin
                    for (int i = hit; i + 1 < shadow_fill; i++) begin
                        shadow_ids[i]   = shadow_ids[i+1];
                        shadow_prios[i] = shadow_prios[i+1];
                    end
                    shadow_fill--;
                end
            end
            default: begin
                res.status = (hit < 0) ? STAT_NOTFOUND : STAT_DONE;
            end
        endcase
        res.found      = (hit >= 0);
        res.count      = CNT_W'(shadow_fill);
        res.head_valid = (shadow_fill > 0);
        res.head_id    = (shadow_fill > 0) ? shadow_ids[0] : '0;
        return res;
    endfunction

    task automatic add_request(input t_func f, input logic [ID_W-1:0] id,
                               input logic [PRIO_W-1:0] prio);
        t_request req;
        req.func = f;
        req.id   = id;
        req.prio = prio;
        requests_pending.push_back(req);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Stimulus, then the end of the run once every result word has come back.
    initial begin
        logic [ID_W-1:0]   id_pool [POOL_SIZE];
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        t_func             f;
        int                made;
        int                phase;
        int                phase_left;
        int                pick;
        int                cut_ordered;
        int                cut_front;
        int                cut_remove;

        // Directed opening: empty-queue misses, extreme fields, equal counts, a duplicate
        // identifier, removal of an absent identifier, then a full queue refusing both kinds
        // of insert.
        add_request(FUNC_QUERY,   16'h0000, 16'h0000);
        add_request(FUNC_REMOVE,  16'hFFFF, 16'hFFFF);
        add_request(FUNC_ORDERED, 16'hFFFF, 16'h0000);
        add_request(FUNC_ORDERED, 16'h0000, 16'hFFFF);
        add_request(FUNC_ORDERED, 16'h1234, 16'hFFFF);
        add_request(FUNC_FRONT,   16'hAAAA, 16'h5555);
        add_request(FUNC_ORDERED, 16'hFFFF, 16'h8000);
        add_request(FUNC_QUERY,   16'hFFFF, 16'h0000);
        add_request(FUNC_REMOVE,  16'hFFFF, 16'h0000);
        add_request(FUNC_REMOVE,  16'h7777, 16'h0000);
        for (int i = 0; i < 12; i++)
            add_request((i % 3 == 0) ? FUNC_FRONT : FUNC_ORDERED,
                        ID_W'($urandom), PRIO_W'($urandom));
        add_request(FUNC_ORDERED, 16'h5555, 16'hFFFF);
        add_request(FUNC_FRONT,   16'h5555, 16'h0000);
        add_request(FUNC_REMOVE,  16'hAAAA, 16'h0000);

        // A small identifier pool keeps removes and queries hitting stored entries.
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom);

        // Random traffic in phases that lean toward filling, draining or a mix, so the
        // fill level sweeps between empty and full.
        made = 0;
        phase_left = 0;
        phase = 0;
        while (made < RANDOM_WORDS) begin
            if (phase_left == 0) begin
                phase = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            case (phase)
                0: begin
                    cut_ordered = 45; cut_front = 65; cut_remove = 85;
                end
                1: begin
                    cut_ordered = 8; cut_front = 13; cut_remove = 85;
                end
                default: begin
                    cut_ordered = 30; cut_front = 45; cut_remove = 80;
                end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < cut_ordered)
                f = FUNC_ORDERED;
            else if (pick < cut_front)
                f = FUNC_FRONT;
            else if (pick < cut_remove)
                f = FUNC_REMOVE;
            else
                f = FUNC_QUERY;
            // Stray identifiers only on removes and queries, so they never clog the queue.
            if ((f == FUNC_REMOVE || f == FUNC_QUERY) && $urandom_range(0, 9) == 0)
                id = ID_W'($urandom);
            else
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            case ($urandom_range(0, 9))
                0: prio = 16'h0000;
                1: prio = 16'hFFFF;
                2: prio = 16'h8000;
                3: prio = 16'h7FFF;
                default: prio = PRIO_W'($urandom);
            endcase
            add_request(f, id, prio);
            made++;
        end

        // Sample at the falling edge so the driver's updates have settled.
        @(negedge i_clk);
        while (requests_pending.size() != 0 || i_valid || outcomes_due.size() != 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Request driver. The word on the bus is predicted at the edge that accepts it, and
    // the next word goes out in the same edge unless the burst has ended in a gap or no word is left.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                outcomes_due.push_back(queue_apply(word_on_bus));
                words_taken <= words_taken + 1;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0 || requests_pending.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    word_on_bus = requests_pending.pop_front();
                    i_func         <= word_on_bus.func;
                    i_thread_id    <= word_on_bus.id;
                    i_priority_req <= word_on_bus.prio;
                    i_valid        <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Long hold-off on the result side: while it runs the result register stays full, the
    // queue drops o_ready and the driver keeps offering its word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (words_taken >= next_hold_at) begin
            hold_left <= 80;
            next_hold_at <= next_hold_at + 600;
        end
    end

    // Result receiver. Its stall pattern changes between always ready, mostly ready, coin toss
    // and mostly stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 120);
            end else begin
                rx_left--;
            end
            if (hold_left != 0)
                i_ready <= 1'b0;
            else
                case (rx_mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 3) != 0);
                    2: i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // Result monitor: every accepted result word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid && i_ready) begin
            if (outcomes_due.size() == 0) begin
                $display("%0t: result word with none expected, status %0d count %0d",
                         $time, o_status, o_count);
                errors++;
            end else begin
                want = outcomes_due.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("found", 32'(want.found), 32'(o_found));
                check_field("count", 32'(want.count), 32'(o_count));
                check_field("head_valid", 32'(want.head_valid), 32'(o_head_valid));
                check_field("head_id", 32'(want.head_id), 32'(o_head_id));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
